// ===== rtl/frwl_pkg.sv =====
`timescale 1ns / 1ps

package frwl_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int ID_W        = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int RDR_W       = 5;
	localparam logic [RDR_W-1:0] READERS_MAX = 5'd31;

	typedef enum logic [1:0] {
		OP_RD_ACQ = 2'd0,
		OP_WR_ACQ = 2'd1,
		OP_RD_REL = 2'd2,
		OP_WR_REL = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		RK_QUEUED   = 3'd0,
		RK_GRANTED  = 3'd1,
		RK_RELEASED = 3'd2,
		RK_FULL     = 3'd3,
		RK_NOHOLDER = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0]      operation;
		logic [ID_W-1:0] requester_id;
	} req_t;

	typedef struct packed {
		logic [2:0]      result_kind;
		logic [ID_W-1:0] holder_id;
		logic            is_writer;
		logic            last;
	} res_t;

	typedef struct packed {
		logic            release_op;
		logic            writer;
		logic [ID_W-1:0] id;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_t;

	typedef struct packed {
		logic            writer;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_PASS
	} state_t;

endpackage

// ===== rtl/frwl_front.sv =====
`timescale 1ns / 1ps

module frwl_front import frwl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  req_t  request,
	input  logic  pop,
	output cmdq_t head
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_in;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;

	always_comb begin
		unique case (op_t'(request.operation))
			OP_RD_ACQ: begin cmd_in.release_op = 1'b0; cmd_in.writer = 1'b0; end
			OP_WR_ACQ: begin cmd_in.release_op = 1'b0; cmd_in.writer = 1'b1; end
			OP_RD_REL: begin cmd_in.release_op = 1'b1; cmd_in.writer = 1'b0; end
			default:   begin cmd_in.release_op = 1'b1; cmd_in.writer = 1'b1; end
		endcase
		cmd_in.id = request.requester_id;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/frwl_back.sv =====
`timescale 1ns / 1ps

module frwl_back import frwl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmdq_t head,
	output logic  pop,
	output logic  strobe,
	output res_t  result
);

	entry_t            wq_q [QUEUE_DEPTH];
	state_t            state_q, state_d;
	logic [QIDX_W-1:0] head_q, head_d;
	logic [QCNT_W-1:0] count_q, count_d;
	logic [RDR_W-1:0]  readers_q, readers_d;
	logic              writer_q, writer_d;
	logic [NCNT_W-1:0] n_q, n_d;
	logic              rg_q, rg_d;
	logic [ID_W-1:0]   rel_id_q, rel_id_d;
	logic              rel_wr_q, rel_wr_d;
	logic              pend_v_q, pend_v_d;
	logic [ID_W-1:0]   pend_id_q, pend_id_d;
	logic              strobe_q, strobe_d;
	res_t              res_q, res_d;
	logic              wq_we;
	entry_t            wq_wdata;
	logic [QIDX_W-1:0] tail;
	logic [QCNT_W:0]   tail_sum;
	logic [QIDX_W-1:0] head_inc;
	entry_t            e;
	logic              grant_now;

	assign tail_sum = {{(QCNT_W + 1 - QIDX_W){1'b0}}, head_q} + {1'b0, count_q};
	assign tail = (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
		? QIDX_W'(tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
	assign head_inc = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign e = wq_q[head_q];

	assign pop    = (state_q == ST_IDLE) && head.valid;
	assign strobe = strobe_q;
	assign result = res_q;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		readers_d = readers_q;
		writer_d  = writer_q;
		n_d       = n_q;
		rg_d      = rg_q;
		rel_id_d  = rel_id_q;
		rel_wr_d  = rel_wr_q;
		pend_v_d  = pend_v_q;
		pend_id_d = pend_id_q;
		strobe_d  = 1'b0;
		res_d     = res_q;
		wq_we     = 1'b0;
		wq_wdata  = '{writer: head.cmd.writer, id: head.cmd.id};
		grant_now = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					strobe_d = 1'b1;
					res_d = '{result_kind: 3'(RK_QUEUED), holder_id: head.cmd.id,
						is_writer: head.cmd.writer, last: 1'b1};
					if (!head.cmd.release_op) begin
						grant_now = (count_q == '0) && !writer_q &&
							(!head.cmd.writer || (readers_q == '0));
						if (grant_now) begin
							res_d.result_kind = 3'(RK_GRANTED);
							if (head.cmd.writer) begin
								writer_d = 1'b1;
							end else if (readers_q != READERS_MAX) begin
								readers_d = readers_q + 1'b1;
							end
						end else if (count_q == QCNT_W'(QUEUE_DEPTH)) begin
							res_d.result_kind = 3'(RK_FULL);
						end else begin
							wq_we   = 1'b1;
							count_d = count_q + 1'b1;
						end
					end else if (head.cmd.writer ? !writer_q : (readers_q == '0)) begin
						res_d.result_kind = 3'(RK_NOHOLDER);
					end else begin
						strobe_d = 1'b0;
						if (head.cmd.writer) begin
							writer_d = 1'b0;
						end else begin
							readers_d = readers_q - 1'b1;
						end
						rel_id_d = head.cmd.id;
						rel_wr_d = head.cmd.writer;
						n_d      = '0;
						rg_d     = 1'b0;
						pend_v_d = 1'b0;
						state_d  = ST_PASS;
					end
				end
			end
			ST_PASS: begin
				if (count_q != '0 && n_q != NCNT_W'(MAX_RESULTS) && !e.writer) begin
					// reader grant; previous one is now known not to be last
					if (pend_v_q) begin
						strobe_d = 1'b1;
						res_d = '{result_kind: 3'(RK_GRANTED), holder_id: pend_id_q,
							is_writer: 1'b0, last: 1'b0};
					end
					pend_v_d  = 1'b1;
					pend_id_d = e.id;
					head_d    = head_inc;
					count_d   = count_q - 1'b1;
					n_d       = n_q + 1'b1;
					rg_d      = 1'b1;
					if (readers_q != READERS_MAX) begin
						readers_d = readers_q + 1'b1;
					end
				end else begin
					strobe_d = 1'b1;
					state_d  = ST_IDLE;
					pend_v_d = 1'b0;
					if (count_q != '0 && n_q != NCNT_W'(MAX_RESULTS) &&
						readers_q == '0 && !writer_q && !rg_q) begin
						res_d = '{result_kind: 3'(RK_GRANTED), holder_id: e.id,
							is_writer: 1'b1, last: 1'b1};
						head_d   = head_inc;
						count_d  = count_q - 1'b1;
						writer_d = 1'b1;
					end else if (pend_v_q) begin
						res_d = '{result_kind: 3'(RK_GRANTED), holder_id: pend_id_q,
							is_writer: 1'b0, last: 1'b1};
					end else begin
						res_d = '{result_kind: 3'(RK_RELEASED), holder_id: rel_id_q,
							is_writer: rel_wr_q, last: 1'b1};
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wq_we) begin
			wq_q[tail] <= wq_wdata;
		end
		res_q     <= res_d;
		rel_id_q  <= rel_id_d;
		rel_wr_q  <= rel_wr_d;
		pend_id_q <= pend_id_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			readers_q <= '0;
			writer_q  <= 1'b0;
			n_q       <= '0;
			rg_q      <= 1'b0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			readers_q <= readers_d;
			writer_q  <= writer_d;
			n_q       <= n_d;
			rg_q      <= rg_d;
			pend_v_q  <= pend_v_d;
			strobe_q  <= strobe_d;
		end
	end

endmodule

// ===== rtl/fifo_fair_reader_writer_lock.sv =====
`timescale 1ns / 1ps
// The command queue registers each accepted request, and the executor registers every result.
// An acquire, or a release with no holder, is decided in the idle state. A release that frees a hold
// enters a pass that grants queued readers in order, holding each grant until the next shows it is
// not last, and ends on a writer grant, the last reader grant or a released result.
// The executor pops no new command during a pass, and it grants at most MAX_RESULTS waiters per pass.
// A 2-entry command queue decouples intake; busy is high while it is full.
// Reset (arst_n low): empty queues, no holders, no pending result. Results cannot be stalled.

module fifo_fair_reader_writer_lock import frwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic strobe,
	output res_t result
);

	cmdq_t head;
	logic  pop;

	frwl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.pop     (pop),
		.head    (head)
	);

	frwl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import frwl_pkg::*;

	localparam int CYC_LIMIT = 300000;
	localparam int DRAIN_CYC = 40;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic strobe;
	res_t result;

	fifo_fair_reader_writer_lock dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result)
	);

	// lock state mirror
	entry_t             wait_mem [QUEUE_DEPTH];
	logic [QIDX_W-1:0]  wait_head;
	logic [QCNT_W-1:0]  wait_count;
	logic [RDR_W-1:0]   reader_cnt;
	logic               writer_held;

	res_t  grant_q[$];
	int    err_cnt;
	int    cyc_cnt;
	int    req_cnt;
	int    res_cnt;
	int    grant_cnt;
	int    full_cnt;
	int    noholder_cnt;
	bit    idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_result(kind_t kind, logic [ID_W-1:0] id, logic wr, logic lst);
		res_t r;
		r.result_kind = kind;
		r.holder_id   = id;
		r.is_writer   = wr;
		r.last        = lst;
		grant_q.push_back(r);
	endfunction

	function automatic void reader_up();
		if (reader_cnt != READERS_MAX)
			reader_cnt = reader_cnt + 1'b1;
	endfunction

	function automatic void lock_predict(req_t r);
		op_t               op;
		logic              wr;
		logic [ID_W-1:0]   id;
		logic [QIDX_W-1:0] tail;
		entry_t            e;
		int                n;
		bit                rd_granted;
		op = op_t'(r.operation);
		id = r.requester_id;
		wr = (op == OP_WR_ACQ) || (op == OP_WR_REL);
		if (op == OP_RD_ACQ || op == OP_WR_ACQ) begin
			if (wait_count == 0 && !writer_held && (!wr || reader_cnt == 0)) begin
				if (wr)
					writer_held = 1'b1;
				else
					reader_up();
				add_result(RK_GRANTED, id, wr, 1'b1);
			end else if (wait_count == QUEUE_DEPTH) begin
				add_result(RK_FULL, id, wr, 1'b1);
			end else begin
				tail = wait_head + wait_count[QIDX_W-1:0];
				wait_mem[tail] = '{writer: wr, id: id};
				wait_count = wait_count + 1'b1;
				add_result(RK_QUEUED, id, wr, 1'b1);
			end
			return;
		end
		if (wr ? !writer_held : (reader_cnt == 0)) begin
			add_result(RK_NOHOLDER, id, wr, 1'b1);
			return;
		end
		if (wr)
			writer_held = 1'b0;
		else
			reader_cnt = reader_cnt - 1'b1;
		n = 0;
		rd_granted = 0;
		while (wait_count != 0 && n < MAX_RESULTS) begin
			e = wait_mem[wait_head];
			if (e.writer) begin
				if (reader_cnt == 0 && !writer_held && !rd_granted) begin
					wait_head = wait_head + 1'b1;
					wait_count = wait_count - 1'b1;
					writer_held = 1'b1;
					add_result(RK_GRANTED, e.id, 1'b1, 1'b0);
					n++;
				end
				break;
			end
			wait_head = wait_head + 1'b1;
			wait_count = wait_count - 1'b1;
			reader_up();
			rd_granted = 1;
			add_result(RK_GRANTED, e.id, 1'b0, 1'b0);
			n++;
		end
		if (n == 0)
			add_result(RK_RELEASED, id, wr, 1'b1);
		else
			grant_q[$].last = 1'b1;
	endfunction

	task automatic send_req(op_t op, logic [ID_W-1:0] id);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 33) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		request <= '{operation: op, requester_id: id};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		lock_predict('{operation: op, requester_id: id});
		req_cnt++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt > CYC_LIMIT) begin
			$display("Timeout after %0d cycles", cyc_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && strobe) begin
			res_cnt++;
			case (kind_t'(result.result_kind))
				RK_GRANTED:  grant_cnt++;
				RK_FULL:     full_cnt++;
				RK_NOHOLDER: noholder_cnt++;
				default: ;
			endcase
			if (grant_q.size() == 0) begin
				$error("unexpected result kind=%0d id=%0d", result.result_kind,
					result.holder_id);
				err_cnt++;
			end else begin
				want = grant_q.pop_front();
				if (result.result_kind !== want.result_kind) begin
					$error("result_kind: expected %0d, got %0d", want.result_kind,
						result.result_kind);
					err_cnt++;
				end
				if (result.holder_id !== want.holder_id) begin
					$error("holder_id: expected %0d, got %0d", want.holder_id,
						result.holder_id);
					err_cnt++;
				end
				if (result.is_writer !== want.is_writer) begin
					$error("is_writer: expected %0d, got %0d", want.is_writer,
						result.is_writer);
					err_cnt++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					err_cnt++;
				end
			end
		end
	end

	task automatic test_no_holder();
		send_req(OP_RD_REL, 4'd0);
		send_req(OP_WR_REL, 4'd15);
	endtask

	task automatic test_fifo_order();
		send_req(OP_RD_ACQ, 4'd0);
		send_req(OP_RD_ACQ, 4'd15);
		send_req(OP_WR_ACQ, 4'd5);
		send_req(OP_RD_ACQ, 4'd3);
		send_req(OP_WR_ACQ, 4'd10);
		send_req(OP_RD_REL, 4'd0);
		send_req(OP_RD_REL, 4'd15);
		send_req(OP_WR_REL, 4'd5);
		send_req(OP_RD_REL, 4'd3);
		send_req(OP_WR_REL, 4'd10);
	endtask

	task automatic test_long_pass();
		send_req(OP_WR_ACQ, 4'd9);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_req(OP_RD_ACQ, i[ID_W-1:0]);
		send_req(OP_WR_ACQ, 4'd12);
		send_req(OP_WR_REL, 4'd9);
	endtask

	// 16 readers already hold; 16 more would push the count past its ceiling of 31, so it saturates there
	task automatic test_saturation();
		for (int i = 0; i < 16; i++)
			send_req(OP_RD_ACQ, 4'(15 - i));
		repeat (32) send_req(OP_RD_REL, 4'(7));
	endtask

	task automatic test_random(int n_req);
		op_t  op;
		int   pick;
		for (int i = 0; i < n_req; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				op = $urandom_range(0, 1) ? OP_WR_REL : OP_RD_REL;
			else if (pick < 50)
				op = OP_RD_ACQ;
			else if (pick < 68)
				op = OP_WR_ACQ;
			else if (writer_held && (reader_cnt == 0 || $urandom_range(0, 1)))
				op = OP_WR_REL;
			else if (reader_cnt != 0)
				op = OP_RD_REL;
			else
				op = OP_RD_ACQ;
			send_req(op, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		err_cnt = 0;
		cyc_cnt = 0;
		req_cnt = 0;
		res_cnt = 0;
		grant_cnt = 0;
		full_cnt = 0;
		noholder_cnt = 0;
		idle_on = 1'b1;
		foreach (wait_mem[i])
			wait_mem[i] = '0;
		wait_head = '0;
		wait_count = '0;
		reader_cnt = '0;
		writer_held = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_no_holder();
		test_fifo_order();
		test_long_pass();
		idle_on = 1'b0;
		test_saturation();
		wait_drained();
		idle_on = 1'b1;
		test_random(35);
		wait_drained();
		idle_on = 1'b0;
		test_random(25);
		idle_on = 1'b1;
		test_random(30);
		wait_drained();

		if (grant_q.size() != 0) begin
			$error("%0d expected results never arrived", grant_q.size());
			err_cnt++;
		end
		$display("Sent %0d lock requests, checked %0d results", req_cnt, res_cnt);
		$display("  grants %0d, queue-full rejects %0d, releases without holder %0d",
			grant_cnt, full_cnt, noholder_cnt);
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
